@@ design/mpid_pkg.sv @@
// shared types and constants for the multichannel pid step core
package mpid_pkg;

  // field widths
  localparam int CHAN_W   = 2;
  localparam int TEMP_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int INTEG_W  = 24;
  localparam int DRIVE_W  = 32;
  localparam int DUTY_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // product and sum widths
  localparam int DIFF_W  = TEMP_W + 1;
  localparam int PPROD_W = GAIN_W + TEMP_W;
  localparam int IPROD_W = GAIN_W + INTEG_W;
  localparam int DPROD_W = GAIN_W + DIFF_W;
  localparam int SUM_W   = IPROD_W + 2;

  // drive value has 12 fraction bits
  localparam int FRAC_BITS = 12;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_GAIN    = 3'd0,
    REG_I_GAIN    = 3'd1,
    REG_D_GAIN    = 3'd2,
    REG_INTEG_MIN = 3'd3,
    REG_INTEG_MAX = 3'd4
  } cfg_reg_t;

endpackage

@@ design/multichannel_pid_step_core.sv @@
// multichannel pid step core: per-channel integral, pid sum, saturation and duty
//
// Input channel (in_valid/in_ready): one item per sensor sample with its channel,
// a restart flag, the measured temperature and the error, both signed Q11.4.
// Result channel (out_valid/out_ready): one item per input item, in order, with
// the channel echoed, the saturated Q19.12 drive value and a 0..100 duty.
// Gains and integral clamps are written through cfg_wr_en/cfg_index/cfg_wdata;
// the user must write them only while no item is in flight, which the block
// itself does not enforce. Writes take effect at once, unknown indexes are dropped.
// An accepted item passes the input register, the integral update, the
// multiply, then sum and saturate into the result register. Throughput: one
// item per cycle while the receiver does not stall, set by the four-stage pipeline;
// per-channel state is updated as an item leaves the input register, so items
// on the same channel may follow each other in consecutive cycles.
// Reset clears gains, clamps, every channel's integral and last temperature and
// empties the pipeline. When the receiver stalls, each stage holds its item and
// empty stages still fill, so up to four items are taken before in_ready drops.
module multichannel_pid_step_core #(
  parameter int CHANNELS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [mpid_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mpid_pkg::CFG_DAT_W-1:0]       cfg_wdata,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mpid_pkg::CHAN_W-1:0]          in_channel,
  input  logic                                 in_restart,
  input  logic signed [mpid_pkg::TEMP_W-1:0]   in_temperature,
  input  logic signed [mpid_pkg::TEMP_W-1:0]   in_error,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mpid_pkg::CHAN_W-1:0]          out_channel,
  output logic signed [mpid_pkg::DRIVE_W-1:0]  out_drive_value,
  output logic [mpid_pkg::DUTY_W-1:0]          out_duty_percent
);
  import mpid_pkg::*;

  localparam int SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic signed [INTEG_W:0] INTEG_TOP    = (INTEG_W+1)'(8388607);
  localparam logic signed [INTEG_W:0] INTEG_BOTTOM = -(INTEG_W+1)'(8388608);
  localparam logic signed [SUM_W-1:0] DRIVE_TOP    = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] DRIVE_BOTTOM = -SUM_W'(64'sd2147483648);

  // configuration registers
  logic signed [GAIN_W-1:0]  p_gain_r, i_gain_r, d_gain_r;
  logic signed [INTEG_W-1:0] integ_min_r, integ_max_r;

  // per-channel state
  logic signed [INTEG_W-1:0] integral_r [CHANNELS];
  logic signed [TEMP_W-1:0]  last_temp_r [CHANNELS];

  // stage 1: input register
  logic                      s1_v_r;
  logic [CHAN_W-1:0]         s1_chan_r;
  logic                      s1_restart_r;
  logic signed [TEMP_W-1:0]  s1_temp_r, s1_err_r;

  // stage 2: updated integral and temperature difference
  logic                      s2_v_r;
  logic [CHAN_W-1:0]         s2_chan_r;
  logic signed [TEMP_W-1:0]  s2_err_r;
  logic signed [INTEG_W-1:0] s2_acc_r;
  logic signed [DIFF_W-1:0]  s2_diff_r;

  // stage 3: products
  logic                      s3_v_r;
  logic [CHAN_W-1:0]         s3_chan_r;
  logic signed [PPROD_W-1:0] s3_p_r;
  logic signed [IPROD_W-1:0] s3_i_r;
  logic signed [DPROD_W-1:0] s3_d_r;

  // result register
  logic                      out_v_r;
  logic [CHAN_W-1:0]         out_chan_r;
  logic signed [DRIVE_W-1:0] out_drive_r;
  logic [DUTY_W-1:0]         out_duty_r;

  // stage handshakes
  logic rdy4, rdy3, rdy2, rdy1;

  always_comb begin
    rdy4 = !out_v_r || out_ready;
    rdy3 = !s3_v_r || rdy4;
    rdy2 = !s2_v_r || rdy3;
    rdy1 = !s1_v_r || rdy2;
  end

  assign in_ready = rdy1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r    <= '0;
      i_gain_r    <= '0;
      d_gain_r    <= '0;
      integ_min_r <= '0;
      integ_max_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_P_GAIN:    p_gain_r    <= cfg_wdata[GAIN_W-1:0];
        REG_I_GAIN:    i_gain_r    <= cfg_wdata[GAIN_W-1:0];
        REG_D_GAIN:    d_gain_r    <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_MIN: integ_min_r <= cfg_wdata[INTEG_W-1:0];
        REG_INTEG_MAX: integ_max_r <= cfg_wdata[INTEG_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_chan_r    <= in_channel;
      s1_restart_r <= in_restart;
      s1_temp_r    <= in_temperature;
      s1_err_r     <= in_error;
    end
  end

  // integral update for the channel in stage 1
  logic [CHAN_W-1:0]         chan_mod;
  logic [SLOT_W-1:0]         slot;
  logic signed [INTEG_W-1:0] integ_base, acc_nxt;
  logic signed [TEMP_W-1:0]  last_base;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [DIFF_W-1:0]  diff_nxt;
  logic                      s1_move;

  always_comb begin
    // channel folded onto the state slots by repeated subtraction
    chan_mod = s1_chan_r;
    for (int k = 0; k < (1 << CHAN_W) - 1; k++) begin
      if (chan_mod >= CHANNELS) begin
        chan_mod = chan_mod - CHAN_W'(CHANNELS);
      end
    end
    slot       = SLOT_W'(chan_mod);
    integ_base = s1_restart_r ? '0 : integral_r[slot];
    last_base  = s1_restart_r ? '0 : last_temp_r[slot];
    integ_sum  = (INTEG_W+1)'(integ_base) + (INTEG_W+1)'(s1_err_r);
    if (integ_sum > INTEG_TOP) begin
      acc_nxt = INTEG_TOP[INTEG_W-1:0];
    end else if (integ_sum < INTEG_BOTTOM) begin
      acc_nxt = INTEG_BOTTOM[INTEG_W-1:0];
    end else begin
      acc_nxt = integ_sum[INTEG_W-1:0];
    end
    if (integ_min_r < integ_max_r) begin
      if (acc_nxt > integ_max_r) begin
        acc_nxt = integ_max_r;
      end else if (acc_nxt < integ_min_r) begin
        acc_nxt = integ_min_r;
      end
    end
    diff_nxt = DIFF_W'(last_base) - DIFF_W'(s1_temp_r);
    s1_move  = s1_v_r && rdy2;
  end

  // channel state, written as the item leaves stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        integral_r[i]  <= '0;
        last_temp_r[i] <= '0;
      end
    end else if (s1_move) begin
      integral_r[slot]  <= acc_nxt;
      last_temp_r[slot] <= s1_temp_r;
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_chan_r <= s1_chan_r;
      s2_err_r  <= s1_err_r;
      s2_acc_r  <= acc_nxt;
      s2_diff_r <= diff_nxt;
    end
  end

  // stage 3: the three gain products
  logic signed [PPROD_W-1:0] p_prod;
  logic signed [IPROD_W-1:0] i_prod;
  logic signed [DPROD_W-1:0] d_prod;

  always_comb begin
    p_prod = p_gain_r * s2_err_r;
    i_prod = i_gain_r * s2_acc_r;
    d_prod = d_gain_r * s2_diff_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && rdy3) begin
      s3_chan_r <= s2_chan_r;
      s3_p_r    <= p_prod;
      s3_i_r    <= i_prod;
      s3_d_r    <= d_prod;
    end
  end

  // sum, saturation and duty
  logic signed [SUM_W-1:0]   pid_sum;
  logic signed [DRIVE_W-1:0] drive_nxt;
  logic [DUTY_W-1:0]         duty_nxt;
  logic [DRIVE_W-FRAC_BITS-2:0] drive_int;

  always_comb begin
    pid_sum = SUM_W'(s3_p_r) + SUM_W'(s3_i_r) + SUM_W'(s3_d_r);
    if (pid_sum > DRIVE_TOP) begin
      drive_nxt = DRIVE_TOP[DRIVE_W-1:0];
    end else if (pid_sum < DRIVE_BOTTOM) begin
      drive_nxt = DRIVE_BOTTOM[DRIVE_W-1:0];
    end else begin
      drive_nxt = pid_sum[DRIVE_W-1:0];
    end
    drive_int = drive_nxt[DRIVE_W-2:FRAC_BITS];
    if (drive_nxt[DRIVE_W-1]) begin
      duty_nxt = '0;
    end else if (drive_int > (DRIVE_W-FRAC_BITS-1)'(DUTY_MAX)) begin
      duty_nxt = DUTY_MAX;
    end else begin
      duty_nxt = drive_int[DUTY_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy4) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && rdy4) begin
      out_chan_r  <= s3_chan_r;
      out_drive_r <= drive_nxt;
      out_duty_r  <= duty_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_channel      = out_chan_r;
  assign out_drive_value  = out_drive_r;
  assign out_duty_percent = out_duty_r;

  // updated integral respects an active clamp
  a_clamp_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && (integ_min_r < integ_max_r) |->
      (s2_acc_r >= integ_min_r) && (s2_acc_r <= integ_max_r))
    else $error("integral outside active clamp");

  // duty never above full scale
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_duty_r <= DUTY_MAX)
    else $error("duty above full scale");

  // negative drive gives zero duty
  a_duty_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_drive_r[DRIVE_W-1] |-> out_duty_r == '0)
    else $error("negative drive with nonzero duty");

  // a product stage item is not dropped while the result register stalls
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !rdy4 |=> s3_v_r && $stable(s3_i_r))
    else $error("stage 3 item lost under stall");

  // a channel's stored temperature follows the item that left stage 1
  a_last_temp: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> last_temp_r[$past(slot)] == $past(s1_temp_r))
    else $error("last temperature not updated");

endmodule

@@ tb/multichannel_pid_step_core_test.sv @@
// self-checking testbench for the multichannel pid step core
module multichannel_pid_step_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mpid_pkg::*;

  localparam int CHANNELS     = 4;
  localparam int QUIET_LIMIT  = 4000;
  localparam int GAP_CAP      = 30;
  localparam int DRAIN_CYCLES = 8;

  localparam logic signed [TEMP_W-1:0] TEMP_TOP    = {1'b0, {(TEMP_W-1){1'b1}}};
  localparam logic signed [TEMP_W-1:0] TEMP_BOTTOM = {1'b1, {(TEMP_W-1){1'b0}}};
  localparam logic signed [GAIN_W-1:0] GAIN_TOP    = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic signed [GAIN_W-1:0] GAIN_BOTTOM = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam logic signed [GAIN_W-1:0] GAIN_ONE    = 16'sh0100;

  localparam longint INTEG_HI = (longint'(1) << (INTEG_W-1)) - 1;
  localparam longint INTEG_LO = -(longint'(1) << (INTEG_W-1));
  localparam longint DRIVE_HI = (longint'(1) << (DRIVE_W-1)) - 1;
  localparam longint DRIVE_LO = -(longint'(1) << (DRIVE_W-1));

  typedef struct packed {
    logic [CHAN_W-1:0]         chan;
    logic signed [DRIVE_W-1:0] drive;
    logic [DUTY_W-1:0]         duty;
  } pid_result_t;

  // block ports
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DAT_W-1:0]       cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CHAN_W-1:0]          in_channel = '0;
  logic                       in_restart = 1'b0;
  logic signed [TEMP_W-1:0]   in_temperature = '0;
  logic signed [TEMP_W-1:0]   in_error = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [CHAN_W-1:0]          out_channel;
  logic signed [DRIVE_W-1:0]  out_drive_value;
  logic [DUTY_W-1:0]          out_duty_percent;

  // shadow of the gain set, clamps and per-channel loop state
  logic signed [GAIN_W-1:0]  p_gain_q = '0;
  logic signed [GAIN_W-1:0]  i_gain_q = '0;
  logic signed [GAIN_W-1:0]  d_gain_q = '0;
  logic signed [INTEG_W-1:0] integ_min_q = '0;
  logic signed [INTEG_W-1:0] integ_max_q = '0;
  logic signed [INTEG_W-1:0] integral_mem [CHANNELS] = '{default: '0};
  logic signed [TEMP_W-1:0]  last_temp_mem [CHANNELS] = '{default: '0};

  pid_result_t pending_results[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  multichannel_pid_step_core #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_channel(in_channel),
    .in_restart(in_restart),
    .in_temperature(in_temperature),
    .in_error(in_error),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_channel(out_channel),
    .out_drive_value(out_drive_value),
    .out_duty_percent(out_duty_percent)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one pid step on the shadow state, returns the drive and duty it yields
  function automatic pid_result_t pid_step(logic [CHAN_W-1:0] ch, logic restart,
                                           logic signed [TEMP_W-1:0] temp,
                                           logic signed [TEMP_W-1:0] err);
    int          slot;
    longint      integ_sum;
    longint      pterm;
    longint      iterm;
    longint      dterm;
    longint      total;
    longint      duty_int;
    pid_result_t r;
    slot = ch % CHANNELS;
    if (restart) begin
      integral_mem[slot]  = '0;
      last_temp_mem[slot] = '0;
    end
    pterm = longint'(p_gain_q) * longint'(err);
    // integrator saturates at 24 bits, then clamps only when the window is valid
    integ_sum = clip(longint'(integral_mem[slot]) + longint'(err), INTEG_LO, INTEG_HI);
    if (integ_min_q < integ_max_q)
      integ_sum = clip(integ_sum, longint'(integ_min_q), longint'(integ_max_q));
    integral_mem[slot] = integ_sum[INTEG_W-1:0];
    iterm = longint'(i_gain_q) * integ_sum;
    // derivative on measurement
    dterm = longint'(d_gain_q) * (longint'(last_temp_mem[slot]) - longint'(temp));
    last_temp_mem[slot] = temp;
    total = clip(pterm + iterm + dterm, DRIVE_LO, DRIVE_HI);
    r.chan  = ch;
    r.drive = total[DRIVE_W-1:0];
    if (total < 0) begin
      r.duty = '0;
    end else begin
      duty_int = total >>> FRAC_BITS;
      r.duty = (duty_int > longint'(DUTY_MAX)) ? DUTY_MAX : duty_int[DUTY_W-1:0];
    end
    return r;
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // predict on every accepted item, check every accepted result
  always @(posedge clk) begin
    pid_result_t want;
    if (rst_n && in_valid && in_ready)
      pending_results.push_back(pid_step(in_channel, in_restart, in_temperature, in_error));
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item on channel %0d", out_channel);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_channel !== want.chan) begin
          $error("out_channel expected %0d actual %0d", want.chan, out_channel);
          error_count++;
        end
        if (out_drive_value !== want.drive) begin
          $error("drive_value expected %0d actual %0d", want.drive, out_drive_value);
          error_count++;
        end
        if (out_duty_percent !== want.duty) begin
          $error("duty_percent expected %0d actual %0d", want.duty, out_duty_percent);
          error_count++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  // watchdog on cycles without any handshake
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL multichannel_pid_step_core");
    $finish;
  end

  // one item, with a random idle gap ahead of it
  task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic restart,
                             input logic signed [TEMP_W-1:0] temp,
                             input logic signed [TEMP_W-1:0] err);
    int gap;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < gap_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_channel     <= ch;
    in_restart     <= restart;
    in_temperature <= temp;
    in_error       <= err;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait for every pending result
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_P_GAIN:    p_gain_q    = data[GAIN_W-1:0];
      REG_I_GAIN:    i_gain_q    = data[GAIN_W-1:0];
      REG_D_GAIN:    d_gain_q    = data[GAIN_W-1:0];
      REG_INTEG_MIN: integ_min_q = data[INTEG_W-1:0];
      REG_INTEG_MAX: integ_max_q = data[INTEG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic signed [GAIN_W-1:0] p,
                           input logic signed [GAIN_W-1:0] i,
                           input logic signed [GAIN_W-1:0] d);
    write_reg(REG_P_GAIN, CFG_DAT_W'(p));
    write_reg(REG_I_GAIN, CFG_DAT_W'(i));
    write_reg(REG_D_GAIN, CFG_DAT_W'(d));
  endtask

  task automatic set_clamp(input logic signed [INTEG_W-1:0] lo,
                           input logic signed [INTEG_W-1:0] hi);
    write_reg(REG_INTEG_MIN, CFG_DAT_W'(lo));
    write_reg(REG_INTEG_MAX, CFG_DAT_W'(hi));
  endtask

  // Q11.4 value: extremes, small magnitudes or anything
  function automatic logic signed [TEMP_W-1:0] pick_q114();
    int v;
    case ($urandom_range(9))
      0: v = int'(TEMP_TOP);
      1: v = int'(TEMP_BOTTOM);
      2, 3, 4: v = $urandom_range(4000) - 2000;
      default: v = $urandom;
    endcase
    return v[TEMP_W-1:0];
  endfunction

  function automatic logic signed [GAIN_W-1:0] small_gain();
    int v;
    v = $urandom_range(1024) - 512;
    return v[GAIN_W-1:0];
  endfunction

  // windup > 0 drives channel 0 toward the positive rail, < 0 toward the negative
  task automatic run_random_phase(input int items, input int sender_idle,
                                  input int receiver_stall, input int windup);
    logic [CHAN_W-1:0]        ch;
    logic                     restart;
    logic signed [TEMP_W-1:0] err;
    gap_pct   = sender_idle;
    stall_pct = receiver_stall;
    for (int n = 0; n < items; n++) begin
      // sender holds off until everything in flight has come back
      if (n == items / 2) drain_results();
      ch      = CHAN_W'($urandom_range(CHANNELS - 1));
      restart = ($urandom_range(19) == 0);
      err     = pick_q114();
      if (windup != 0) begin
        if (n == 0 || $urandom_range(29) != 0) ch = '0;
        restart = (n == 0);
        if ($urandom_range(29) != 0) err = (windup > 0) ? TEMP_TOP : TEMP_BOTTOM;
      end
      send_sample(ch, restart, pick_q114(), err);
    end
  endtask

  // gains at their reset value give a zero drive
  task automatic test_reset_defaults();
    send_sample(2'd0, 1'b0, 16'sh1234, TEMP_TOP);
    send_sample(2'd3, 1'b1, TEMP_BOTTOM, TEMP_BOTTOM);
    drain_results();
  endtask

  // term extremes, duty boundaries and drive saturation both ways
  task automatic test_term_extremes();
    set_gains(GAIN_ONE, '0, GAIN_ONE);
    send_sample(2'd2, 1'b1, TEMP_TOP, TEMP_TOP);
    send_sample(2'd2, 1'b0, TEMP_BOTTOM, TEMP_BOTTOM);
    // 100.0, 50.0, 1.0 and -1.0 in Q11.4 with unity p gain
    send_sample(2'd3, 1'b1, '0, 16'sd1600);
    send_sample(2'd3, 1'b1, '0, 16'sd800);
    send_sample(2'd3, 1'b1, '0, 16'sd16);
    send_sample(2'd3, 1'b1, '0, -16'sd16);
    drain_results();
    set_gains(GAIN_BOTTOM, '0, GAIN_BOTTOM);
    // full-scale temperature swing: negative then positive saturation
    send_sample(2'd1, 1'b1, TEMP_TOP, '0);
    send_sample(2'd1, 1'b0, TEMP_BOTTOM, TEMP_TOP);
    send_sample(2'd0, 1'b1, TEMP_BOTTOM, '0);
    send_sample(2'd0, 1'b0, TEMP_TOP, TEMP_BOTTOM);
    drain_results();
  endtask

  // clamp window active, equal bounds, inverted bounds and full range at top i gain
  task automatic test_integral_clamp();
    set_gains('0, GAIN_ONE, '0);
    set_clamp(INTEG_W'(-100), INTEG_W'(100));
    send_sample(2'd0, 1'b1, '0, 16'sd1000);
    send_sample(2'd0, 1'b0, '0, -16'sd5000);
    send_sample(2'd0, 1'b0, '0, 16'sd30);
    drain_results();
    set_clamp(INTEG_W'(50), INTEG_W'(50));
    send_sample(2'd0, 1'b0, '0, 16'sd500);
    drain_results();
    set_clamp(INTEG_W'(200), INTEG_W'(-200));
    send_sample(2'd0, 1'b0, '0, -16'sd1000);
    drain_results();
    write_reg(REG_I_GAIN, CFG_DAT_W'(GAIN_TOP));
    set_clamp(INTEG_W'(INTEG_LO), INTEG_W'(INTEG_HI));
    send_sample(2'd1, 1'b1, '0, TEMP_TOP);
    send_sample(2'd1, 1'b1, '0, TEMP_BOTTOM);
    drain_results();
  endtask

  // writes to unmapped indexes leave the settings alone
  task automatic test_unknown_index();
    for (int idx = REG_INTEG_MAX + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(idx[CFG_IDX_W-1:0], '1);
    send_sample(2'd2, 1'b1, '0, 16'sd16);
    drain_results();
  endtask

  // random items across idle patterns and settings
  task automatic test_random_traffic();
    set_gains(GAIN_W'($urandom_range(65535)), GAIN_W'($urandom_range(65535)),
              GAIN_W'($urandom_range(65535)));
    set_clamp(INTEG_W'($urandom), INTEG_W'($urandom));
    run_random_phase(180, 0, 0, 0);
    drain_results();
    set_gains(small_gain(), small_gain(), small_gain());
    set_clamp(INTEG_W'(-20000), INTEG_W'(20000));
    run_random_phase(180, 74, 0, 0);
    drain_results();
    // integrator windup to the positive 24-bit rail
    set_gains(small_gain(), GAIN_TOP, GAIN_BOTTOM);
    set_clamp('0, '0);
    run_random_phase(300, 0, 74, 1);
    drain_results();
    set_gains(small_gain(), small_gain(), small_gain());
    set_clamp(INTEG_W'(1000), INTEG_W'(-1000));
    run_random_phase(160, 35, 35, 0);
    drain_results();
    // windup to the negative rail with the clamp at full range
    set_gains(small_gain(), GAIN_BOTTOM, small_gain());
    set_clamp(INTEG_W'(INTEG_LO), INTEG_W'(INTEG_HI));
    run_random_phase(280, 0, 0, -1);
    drain_results();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_term_extremes();
    test_integral_clamp();
    test_unknown_index();
    test_random_traffic();
    drain_results();
    if (error_count == 0)
      $display("PASS multichannel_pid_step_core");
    else
      $display("FAIL multichannel_pid_step_core");
    $finish;
  end

endmodule
